/* src/value_to_color_map_defines.svh */
// assertion macros for the value_to_color_map block
// used by the top level only; expects clk and arst_n in scope
`ifndef VALUE_TO_COLOR_MAP_DEFINES_SVH
`define VALUE_TO_COLOR_MAP_DEFINES_SVH

// same-cycle implication, ignored during reset
`define V2CM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("v2cm same-cycle check failed");

// next-cycle implication, ignored during reset
`define V2CM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("v2cm next-cycle check failed");

`endif

/* src/v2cm_pkg.sv */
// shared types, codes, constants and palettes of the value_to_color_map block
// no dependencies
package v2cm_pkg;

	localparam int FRAC_BITS = 16;
	localparam int ONE       = 1 << FRAC_BITS;
	localparam int VALUE_W   = 18;
	localparam int POINT_W   = 17;
	localparam int SCALE_W   = 3;
	localparam int ARGB_W    = 32;
	localparam int SW        = 20;   // mirrored scalar and points
	localparam int XW        = 28;   // scaled band terms
	localparam int PW        = 48;   // products
	localparam int QLEVELS   = 15;   // quantizer thresholds
	localparam int PSTEPS    = 9;    // palette thresholds, largest palette minus one

	// color scale codes
	localparam logic [SCALE_W-1:0] SC_CLASSIC = 3'd0;
	localparam logic [SCALE_W-1:0] SC_RAINBOW = 3'd1;
	localparam logic [SCALE_W-1:0] SC_PURPLE  = 3'd2;
	localparam logic [SCALE_W-1:0] SC_BLUERED = 3'd3;
	localparam logic [SCALE_W-1:0] SC_GREY    = 3'd4;
	localparam logic [SCALE_W-1:0] SC_MONO    = 3'd5;

	// register indexes
	localparam logic [1:0] REG_SCALE = 2'd0;
	localparam logic [1:0] REG_BLUE  = 2'd1;
	localparam logic [1:0] REG_RED   = 2'd2;

	localparam logic [ARGB_W-1:0] ARGB_MISS_GREY  = 32'h0000_0000;
	localparam logic [ARGB_W-1:0] ARGB_MISS_OTHER = 32'h007F_7F7F;
	localparam logic [ARGB_W-1:0] ARGB_BLACK      = 32'hFF00_0000;

	typedef logic signed [SW-1:0] sval_t;
	typedef logic signed [XW-1:0] xval_t;
	typedef logic signed [PW-1:0] prod_t;

	typedef enum logic [2:0] {
		BAND_NONE, BAND_1, BAND_2, BAND_3, BAND_4, BAND_5, BAND_6
	} band_t;

	typedef struct packed {
		logic                 missing;
		logic [SCALE_W-1:0]   scale;
		band_t                band;
		logic                 qd_zero;
		logic                 pden_zero;
		logic                 pnum_zero;
	} ctl_t;

	function automatic logic [23:0] pal_rainbow(input logic [3:0] i);
		logic [23:0] c;
		case (i)
			4'd0: c = 24'h3333DD;
			4'd1: c = 24'h3388DD;
			4'd2: c = 24'h22CCDD;
			4'd3: c = 24'h22CCBB;
			4'd4: c = 24'h22DD88;
			4'd5: c = 24'h88DD22;
			4'd6: c = 24'hBBCC22;
			4'd7: c = 24'hDDCC22;
			4'd8: c = 24'hDD8833;
			default: c = 24'hDD3333;
		endcase
		return c;
	endfunction

	function automatic logic [23:0] pal_grey(input logic [2:0] i);
		logic [23:0] c;
		case (i)
			3'd0: c = 24'h000000;
			3'd1: c = 24'h444444;
			3'd2: c = 24'h777777;
			3'd3: c = 24'hAAAAAA;
			3'd4: c = 24'hCCCCCC;
			3'd5: c = 24'hEEEEEE;
			default: c = 24'hFFFFFF;
		endcase
		return c;
	endfunction

	function automatic logic [23:0] pal_bluered(input logic [2:0] i);
		logic [23:0] c;
		case (i)
			3'd0: c = 24'h4575B4;
			3'd1: c = 24'h91BFDB;
			3'd2: c = 24'hE0F3F8;
			3'd3: c = 24'hFFFFBF;
			3'd4: c = 24'hFEE090;
			3'd5: c = 24'hFC8D59;
			default: c = 24'hD73027;
		endcase
		return c;
	endfunction

	function automatic logic [23:0] pal_purple(input logic [2:0] i);
		logic [23:0] c;
		case (i)
			3'd0: c = 24'h542788;
			3'd1: c = 24'h998EC3;
			3'd2: c = 24'hD8DAEB;
			3'd3: c = 24'hF7F7F7;
			3'd4: c = 24'hFEE0B6;
			3'd5: c = 24'hF1A340;
			default: c = 24'hB35806;
		endcase
		return c;
	endfunction

endpackage

/* src/v2cm_front.sv */
// stages 1 and 2: point mirroring, classic band select, quantizer and palette operands
// depends on v2cm_pkg
module v2cm_front (
	input  logic                              clk,
	input  logic                              adv1,
	input  logic                              adv2,
	input  logic signed [v2cm_pkg::VALUE_W-1:0] value,
	input  logic                              is_missing,
	input  logic [v2cm_pkg::SCALE_W-1:0]      scale,
	input  logic [v2cm_pkg::POINT_W-1:0]      blue_point,
	input  logic [v2cm_pkg::POINT_W-1:0]      red_point,
	output v2cm_pkg::ctl_t                    ctl_s2,
	output v2cm_pkg::xval_t                   qn_s2,
	output v2cm_pkg::xval_t                   qd_s2,
	output v2cm_pkg::xval_t                   pnum_s2,
	output v2cm_pkg::xval_t                   pden_s2
);

	v2cm_pkg::sval_t f_s1, b_s1, r_s1;
	logic missing_s1;
	logic [v2cm_pkg::SCALE_W-1:0] scale_s1;

	v2cm_pkg::sval_t fv, bv, rv, one_s;
	v2cm_pkg::xval_t f, b, r, fs, bs, rs, gs, m1, m2, n, d, pn, pd;
	v2cm_pkg::band_t band;

	// stage 1: sign extend and mirror when blue lies above red
	always_comb begin
		one_s = v2cm_pkg::sval_t'(v2cm_pkg::ONE);
		fv = {{(v2cm_pkg::SW-v2cm_pkg::VALUE_W){value[v2cm_pkg::VALUE_W-1]}}, value};
		bv = {{(v2cm_pkg::SW-v2cm_pkg::POINT_W){1'b0}}, blue_point};
		rv = {{(v2cm_pkg::SW-v2cm_pkg::POINT_W){1'b0}}, red_point};
		if (blue_point > red_point) begin
			fv = one_s - fv;
			bv = one_s - bv;
			rv = one_s - rv;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			f_s1       <= fv;
			b_s1       <= bv;
			r_s1       <= rv;
			missing_s1 <= is_missing;
			scale_s1   <= scale;
		end
	end

	// stage 2: band edges scaled by 20, band choice, operand select
	always_comb begin
		f  = v2cm_pkg::xval_t'(f_s1);
		b  = v2cm_pkg::xval_t'(b_s1);
		r  = v2cm_pkg::xval_t'(r_s1);
		fs = (f <<< 4) + (f <<< 2);
		bs = (b <<< 4) + (b <<< 2);
		rs = (r <<< 4) + (r <<< 2);
		gs = (b <<< 4) + (b <<< 1) + (r <<< 1);
		m1 = (b <<< 4) + (b <<< 1) + b + r;
		m2 = (b <<< 3) + b + (r <<< 3) + (r <<< 1) + r;
		band = v2cm_pkg::BAND_NONE;
		n = '0;
		d = '0;
		if (f >= 0 && f < b) begin
			band = v2cm_pkg::BAND_1;
			n = b - f;
			d = b <<< 1;
		end else if (fs >= bs && fs < m1) begin
			band = v2cm_pkg::BAND_2;
			n = fs - bs;
			d = r - b;
		end else if (fs >= m1 && fs < gs) begin
			band = v2cm_pkg::BAND_3;
			n = gs - fs;
			d = r - b;
		end else if (fs >= gs && fs < m2) begin
			band = v2cm_pkg::BAND_4;
			n = (fs - gs) <<< 1;
			d = rs - gs;
		end else if (fs >= m2 && fs < rs) begin
			band = v2cm_pkg::BAND_5;
			n = (rs - fs) <<< 1;
			d = rs - gs;
		end else if (f >= r) begin
			band = v2cm_pkg::BAND_6;
			n = f - r;
			d = (v2cm_pkg::xval_t'(v2cm_pkg::ONE) - r) <<< 1;
		end
		// quantizer works on a positive denominator
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		pn = f - b;
		pd = r - b;
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			ctl_s2.missing   <= missing_s1;
			ctl_s2.scale     <= scale_s1;
			ctl_s2.band      <= band;
			ctl_s2.qd_zero   <= (d == 0);
			ctl_s2.pden_zero <= (pd == 0);
			ctl_s2.pnum_zero <= (pn == 0);
			qn_s2   <= n;
			qd_s2   <= d;
			pnum_s2 <= pn;
			pden_s2 <= pd;
		end
	end

endmodule

/* src/v2cm_mult.sv */
// stage 3: constant products for quantizer and palette threshold compares
// depends on v2cm_pkg
module v2cm_mult (
	input  logic            clk,
	input  logic            adv3,
	input  v2cm_pkg::ctl_t  ctl_s2,
	input  v2cm_pkg::xval_t qn_s2,
	input  v2cm_pkg::xval_t qd_s2,
	input  v2cm_pkg::xval_t pnum_s2,
	input  v2cm_pkg::xval_t pden_s2,
	output v2cm_pkg::ctl_t  ctl_s3,
	output v2cm_pkg::prod_t qp_s3,
	output v2cm_pkg::prod_t qt_s3 [v2cm_pkg::QLEVELS],
	output v2cm_pkg::prod_t pp_s3,
	output v2cm_pkg::prod_t pt_s3 [v2cm_pkg::PSTEPS]
);

	v2cm_pkg::prod_t pnum_w, pden_w, qd_w;

	assign pnum_w = v2cm_pkg::prod_t'(pnum_s2);
	assign pden_w = v2cm_pkg::prod_t'(pden_s2);
	assign qd_w   = v2cm_pkg::prod_t'(qd_s2);

	always_ff @(posedge clk) begin
		if (adv3) begin
			ctl_s3 <= ctl_s2;
			qp_s3  <= v2cm_pkg::prod_t'(qn_s2) * v2cm_pkg::prod_t'(150000);
			// palette size is ten for the rainbow, seven otherwise
			if (ctl_s2.scale == v2cm_pkg::SC_RAINBOW) begin
				pp_s3 <= pnum_w * v2cm_pkg::prod_t'(10);
			end else begin
				pp_s3 <= pnum_w * v2cm_pkg::prod_t'(7);
			end
		end
	end

	// level k reached when 150000*n >= d*(10000*k - 4995)
	for (genvar k = 0; k < v2cm_pkg::QLEVELS; k++) begin : g_qthr
		always_ff @(posedge clk) begin
			if (adv3) begin
				qt_s3[k] <= qd_w * v2cm_pkg::prod_t'(10000 * (k + 1) - 4995);
			end
		end
	end

	for (genvar k = 0; k < v2cm_pkg::PSTEPS; k++) begin : g_pthr
		always_ff @(posedge clk) begin
			if (adv3) begin
				pt_s3[k] <= pden_w * v2cm_pkg::prod_t'(k + 1);
			end
		end
	end

endmodule

/* src/v2cm_color.sv */
// stage 4: threshold compares, quantized channels, palette lookup, final color
// depends on v2cm_pkg
module v2cm_color (
	input  logic            clk,
	input  logic            adv4,
	input  v2cm_pkg::ctl_t  ctl_s3,
	input  v2cm_pkg::prod_t qp_s3,
	input  v2cm_pkg::prod_t qt_s3 [v2cm_pkg::QLEVELS],
	input  v2cm_pkg::prod_t pp_s3,
	input  v2cm_pkg::prod_t pt_s3 [v2cm_pkg::PSTEPS],
	output logic [v2cm_pkg::ARGB_W-1:0] argb_s4
);

	logic [3:0] lvl, idx, top_idx;
	logic [7:0] q, rd, gr, bl;
	logic [v2cm_pkg::ARGB_W-1:0] col;

	always_comb begin
		// thresholds rise with k, so the last one met gives the level
		lvl = '0;
		for (int k = 0; k < v2cm_pkg::QLEVELS; k++) begin
			if (qp_s3 >= qt_s3[k]) lvl = 4'(k + 1);
		end
		q = ctl_s3.qd_zero ? 8'hFF : {lvl, lvl};

		top_idx = (ctl_s3.scale == v2cm_pkg::SC_RAINBOW) ? 4'd9 : 4'd6;
		idx = '0;
		for (int k = 0; k < v2cm_pkg::PSTEPS; k++) begin
			if (pp_s3 > pt_s3[k] && 4'(k + 1) <= top_idx) idx = 4'(k + 1);
		end
		// zero span with value on the point: middle entry
		if (ctl_s3.pden_zero && ctl_s3.pnum_zero) begin
			idx = (ctl_s3.scale == v2cm_pkg::SC_RAINBOW) ? 4'd4 : 4'd3;
		end

		rd = '0;
		gr = '0;
		bl = '0;
		case (ctl_s3.band)
			v2cm_pkg::BAND_1: begin rd = q;     bl = 8'hFF; end
			v2cm_pkg::BAND_2: begin gr = q;     bl = 8'hFF; end
			v2cm_pkg::BAND_3: begin gr = 8'hFF; bl = q;     end
			v2cm_pkg::BAND_4: begin gr = 8'hFF; rd = q;     end
			v2cm_pkg::BAND_5: begin gr = q;     rd = 8'hFF; end
			v2cm_pkg::BAND_6: begin rd = 8'hFF; bl = q;     end
			default: ;
		endcase

		case (ctl_s3.scale) inside
			v2cm_pkg::SC_CLASSIC: col = {8'hFF, rd, gr, bl};
			v2cm_pkg::SC_RAINBOW: col = {8'hFF, v2cm_pkg::pal_rainbow(idx)};
			v2cm_pkg::SC_PURPLE:  col = {8'hFF, v2cm_pkg::pal_purple(idx[2:0])};
			v2cm_pkg::SC_BLUERED: col = {8'hFF, v2cm_pkg::pal_bluered(idx[2:0])};
			v2cm_pkg::SC_GREY, v2cm_pkg::SC_MONO:
				col = {8'hFF, v2cm_pkg::pal_grey(idx[2:0])};
			default: col = v2cm_pkg::ARGB_BLACK;
		endcase

		if (ctl_s3.missing) begin
			col = (ctl_s3.scale == v2cm_pkg::SC_GREY || ctl_s3.scale == v2cm_pkg::SC_MONO)
				? v2cm_pkg::ARGB_MISS_GREY : v2cm_pkg::ARGB_MISS_OTHER;
		end
	end

	always_ff @(posedge clk) begin
		if (adv4) argb_s4 <= col;
	end

endmodule

/* src/value_to_color_map.sv */
// value_to_color_map: maps a signed Q2.16 scalar to a 32-bit ARGB color.
// One beat is taken per cycle unless the stalled output holds the pipeline
// back. The four register stages are: point mirroring, band and operand
// select, constant products for the quantizer and palette thresholds, and
// the compares with color lookup; the product stage sets the clock. Each
// stage holds its own valid bit, so a stalled output only stops the stages
// that are full and input beats keep filling empty ones. Configuration
// registers take effect for beats accepted after the write; write them with
// the pipeline empty.
// depends on v2cm_pkg, v2cm_front, v2cm_mult, v2cm_color and the defines header
`include "value_to_color_map_defines.svh"

module value_to_color_map (
	input  logic        clk,
	input  logic        arst_n,
	// input beats
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,    // [17:0] value (signed), zero filled above
	input  logic [0:0]  s_tuser,    // [0] is_missing
	// output beats
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,    // [31:0] argb
	// configuration writes
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [16:0] cfg_wdata
);

	logic [v2cm_pkg::SCALE_W-1:0] color_scale_q;
	logic [v2cm_pkg::POINT_W-1:0] blue_point_q, red_point_q;

	// one valid bit per stage, an advance enable per stage
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv1, adv2, adv3, adv4;

	v2cm_pkg::ctl_t  ctl_s2, ctl_s3;
	v2cm_pkg::xval_t qn_s2, qd_s2, pnum_s2, pden_s2;
	v2cm_pkg::prod_t qp_s3, pp_s3;
	v2cm_pkg::prod_t qt_s3 [v2cm_pkg::QLEVELS];
	v2cm_pkg::prod_t pt_s3 [v2cm_pkg::PSTEPS];
	logic [v2cm_pkg::ARGB_W-1:0] argb_s4;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_scale_q <= v2cm_pkg::SC_CLASSIC;
			blue_point_q  <= '0;
			red_point_q   <= v2cm_pkg::POINT_W'(v2cm_pkg::ONE);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				v2cm_pkg::REG_SCALE: color_scale_q <= cfg_wdata[v2cm_pkg::SCALE_W-1:0];
				v2cm_pkg::REG_BLUE:  blue_point_q  <= cfg_wdata;
				v2cm_pkg::REG_RED:   red_point_q   <= cfg_wdata;
				default: ;   // index beyond the register list is ignored
			endcase
		end
	end

	// a stage moves when it is empty or the next one moves
	assign adv4 = !v_s4 || m_tready;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign s_tready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= s_tvalid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	v2cm_front u_front (
		.clk        (clk),
		.adv1       (adv1),
		.adv2       (adv2),
		.value      (s_tdata[v2cm_pkg::VALUE_W-1:0]),
		.is_missing (s_tuser[0]),
		.scale      (color_scale_q),
		.blue_point (blue_point_q),
		.red_point  (red_point_q),
		.ctl_s2     (ctl_s2),
		.qn_s2      (qn_s2),
		.qd_s2      (qd_s2),
		.pnum_s2    (pnum_s2),
		.pden_s2    (pden_s2)
	);

	v2cm_mult u_mult (
		.clk     (clk),
		.adv3    (adv3),
		.ctl_s2  (ctl_s2),
		.qn_s2   (qn_s2),
		.qd_s2   (qd_s2),
		.pnum_s2 (pnum_s2),
		.pden_s2 (pden_s2),
		.ctl_s3  (ctl_s3),
		.qp_s3   (qp_s3),
		.qt_s3   (qt_s3),
		.pp_s3   (pp_s3),
		.pt_s3   (pt_s3)
	);

	v2cm_color u_color (
		.clk     (clk),
		.adv4    (adv4),
		.ctl_s3  (ctl_s3),
		.qp_s3   (qp_s3),
		.qt_s3   (qt_s3),
		.pp_s3   (pp_s3),
		.pt_s3   (pt_s3),
		.argb_s4 (argb_s4)
	);

	assign m_tvalid = v_s4;
	assign m_tdata  = argb_s4;

	// a free output keeps the whole pipeline open
	`V2CM_ASSERT_NOW(a_ready_chain, m_tready, s_tready)
	// an accepted beat lands in the first stage
	`V2CM_ASSERT_NEXT(a_accept_fills, s_tvalid && s_tready, v_s1)
	// alpha is either fully opaque or fully transparent
	`V2CM_ASSERT_NOW(a_alpha_code, m_tvalid && m_tdata[31:24] != 8'hFF, m_tdata[31:24] == 8'h00)

endmodule

/* dv/testbench.sv */
// testbench for value_to_color_map: directed and random scalar beats, colors checked
// against an in-bench predictor of the color scales; depends on v2cm_pkg and the rtl
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [v2cm_pkg::VALUE_W-1:0] value;
		logic                                missing;
	} pixel_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // [17:0] value (signed), zero filled above
	logic [0:0]  s_tuser;   // [0] is_missing
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // [31:0] argb
	logic        cfg_we;
	logic [1:0]  cfg_addr;
	logic [16:0] cfg_wdata;

	value_to_color_map dut (.*);

	// predictor copy of the registers
	logic [v2cm_pkg::SCALE_W-1:0] cur_scale;
	logic [v2cm_pkg::POINT_W-1:0] cur_blue;
	logic [v2cm_pkg::POINT_W-1:0] cur_red;

	pixel_t      pixel_q[$];
	logic [31:0] color_q[$];
	int          errors;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_send;
	int          quiet_cycles;
	logic        s_tready_seen;

	localparam int WATCHDOG = 20000;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// sixteen-step level of n/d as a byte, saturating
	function automatic logic [7:0] web_level(longint n, longint d);
		longint top, lvl;
		if (d == 0)
			return 8'hFF;
		if (d < 0) begin
			n = -n;
			d = -d;
		end
		top = n * 150000 + 4995 * d;
		if (top < 0)
			return 8'h00;
		lvl = top / (d * 10000);
		if (lvl > 15)
			lvl = 15;
		return 8'(lvl * 17);
	endfunction

	function automatic int palette_index(longint num, longint den, longint n);
		longint idx;
		if (den == 0)
			idx = (num == 0) ? (n - 1) / 2 : (num > 0 ? n - 1 : 0);
		else if (num <= 0)
			idx = 0;
		else if (num >= den)
			idx = n - 1;
		else
			idx = (num * n - 1) / den;
		return int'(idx);
	endfunction

	function automatic logic [31:0] classic_color(longint f, longint b, longint r);
		logic [7:0] rd, gr, bl;
		longint bf, bb, br, bg, m1, m2;
		rd = 0; gr = 0; bl = 0;
		bf = 20 * f; bb = 20 * b; br = 20 * r;
		bg = 18 * b + 2 * r;
		m1 = 19 * b + r;
		m2 = 9 * b + 11 * r;
		if (f >= 0 && f < b) begin
			rd = web_level(b - f, 2 * b);
			bl = 8'hFF;
		end else if (bf >= bb && bf < m1) begin
			bl = 8'hFF;
			gr = web_level(20 * (f - b), r - b);
		end else if (bf >= m1 && bf < bg) begin
			bl = web_level(bg - bf, r - b);
			gr = 8'hFF;
		end else if (bf >= bg && bf < m2) begin
			gr = 8'hFF;
			rd = web_level(2 * (bf - bg), br - bg);
		end else if (bf >= m2 && bf < br) begin
			gr = web_level(2 * (br - bf), br - bg);
			rd = 8'hFF;
		end else if (f >= r) begin
			rd = 8'hFF;
			bl = web_level(f - r, 2 * (v2cm_pkg::ONE - r));
		end
		return {8'hFF, rd, gr, bl};
	endfunction

	function automatic logic [31:0] pixel_color(pixel_t p);
		longint f, b, r;
		f = p.value;
		b = cur_blue;
		r = cur_red;
		if (p.missing)
			return (cur_scale == v2cm_pkg::SC_GREY || cur_scale == v2cm_pkg::SC_MONO) ?
				v2cm_pkg::ARGB_MISS_GREY : v2cm_pkg::ARGB_MISS_OTHER;
		// reversed points mirror everything
		if (b > r) begin
			f = v2cm_pkg::ONE - f;
			b = v2cm_pkg::ONE - b;
			r = v2cm_pkg::ONE - r;
		end
		case (cur_scale)
			v2cm_pkg::SC_CLASSIC: return classic_color(f, b, r);
			v2cm_pkg::SC_RAINBOW:
				return {8'hFF, v2cm_pkg::pal_rainbow(4'(palette_index(f - b, r - b, 10)))};
			v2cm_pkg::SC_PURPLE:
				return {8'hFF, v2cm_pkg::pal_purple(3'(palette_index(f - b, r - b, 7)))};
			v2cm_pkg::SC_BLUERED:
				return {8'hFF, v2cm_pkg::pal_bluered(3'(palette_index(f - b, r - b, 7)))};
			v2cm_pkg::SC_GREY, v2cm_pkg::SC_MONO:
				return {8'hFF, v2cm_pkg::pal_grey(3'(palette_index(f - b, r - b, 7)))};
			default:    return v2cm_pkg::ARGB_BLACK;
		endcase
	endfunction

	// driver: new beat at the falling edge once the previous one is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_tready_seen) begin
				if (pixel_q.size() != 0 && !hold_send &&
				    $urandom_range(99) >= send_idle_pct) begin
					s_tvalid <= 1'b1;
					s_tdata  <= {6'd0, pixel_q[0].value};
					s_tuser  <= pixel_q[0].missing;
					color_q.push_back(pixel_color(pixel_q[0]));
					void'(pixel_q.pop_front());
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// accept flag captured at the rising edge
	always @(posedge clk) begin
		s_tready_seen <= s_tvalid && s_tready;
	end

	// monitor: compare each output beat with the oldest expected color
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (m_tvalid && m_tready) begin
				if (color_q.size() == 0) begin
					$error("argb beat with nothing expected: %h", m_tdata);
					errors++;
				end else begin
					if (m_tdata !== color_q[0]) begin
						$error("argb expected %h actual %h", color_q[0], m_tdata);
						errors++;
					end
					void'(color_q.pop_front());
				end
			end
			if (quiet_cycles > WATCHDOG) begin
				$display("testbench failed");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [16:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			v2cm_pkg::REG_SCALE: cur_scale = data[v2cm_pkg::SCALE_W-1:0];
			v2cm_pkg::REG_BLUE:  cur_blue = data;
			default:   cur_red = data;
		endcase
	endtask

	// block until every queued pixel is out and the pipeline has drained
	task automatic drain();
		while (pixel_q.size() != 0 || s_tvalid || color_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_scale(logic [2:0] sc, logic [16:0] bp, logic [16:0] rp);
		drain();
		write_reg(v2cm_pkg::REG_SCALE, {14'd0, sc});
		write_reg(v2cm_pkg::REG_BLUE, bp);
		write_reg(v2cm_pkg::REG_RED, rp);
	endtask

	function automatic logic [16:0] rand_point();
		case ($urandom_range(5))
			0: return 17'd0;
			1: return 17'(v2cm_pkg::ONE);
			2: return 17'h1FFFF;
			default: return 17'($urandom_range(v2cm_pkg::ONE));
		endcase
	endfunction

	// value near one of the points, in the unit range or, sometimes, anywhere in the field
	function automatic pixel_t rand_pixel();
		pixel_t p;
		int c;
		c = $urandom_range(9);
		if (c < 2)
			p.value = v2cm_pkg::VALUE_W'($urandom);
		else if (c < 4)
			p.value = v2cm_pkg::VALUE_W'(cur_blue + $urandom_range(64) - 32);
		else if (c < 6)
			p.value = v2cm_pkg::VALUE_W'(cur_red + $urandom_range(64) - 32);
		else
			p.value = v2cm_pkg::VALUE_W'($urandom_range(v2cm_pkg::ONE));
		p.missing = ($urandom_range(15) == 0);
		return p;
	endfunction

	task automatic push_value(int v, bit miss);
		pixel_t p;
		p.value = v2cm_pkg::VALUE_W'(v);
		p.missing = miss;
		pixel_q.push_back(p);
	endtask

	initial begin
		int phase;
		int sc;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		errors = 0;
		quiet_cycles = 0;
		hold_send = 0;
		send_idle_pct = 9;
		recv_idle_pct = 69;
		cur_scale = v2cm_pkg::SC_CLASSIC;
		cur_blue = '0;
		cur_red = 17'(v2cm_pkg::ONE);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, missing flag, zero span, reversed points, unused codes
		for (sc = 0; sc < 8; sc++) begin
			set_scale(3'(sc), (sc % 2) ? 17'(v2cm_pkg::ONE) : 17'd0,
				(sc % 2) ? 17'd0 : 17'(v2cm_pkg::ONE));
			push_value(0, 0);
			push_value(-131072, 0);
			push_value(131071, 0);
			push_value(-1, 0);
			push_value(v2cm_pkg::ONE / 2, 1);
			push_value(v2cm_pkg::ONE / 3, 0);
		end
		set_scale(v2cm_pkg::SC_RAINBOW, 17'd30000, 17'd30000);
		push_value(30000, 0); push_value(29999, 0); push_value(30001, 0);
		set_scale(v2cm_pkg::SC_CLASSIC, 17'd30000, 17'd30000);
		push_value(30000, 0); push_value(10, 0); push_value(40000, 0);
		set_scale(v2cm_pkg::SC_CLASSIC, 17'h1FFFF, 17'd0);
		push_value(v2cm_pkg::ONE, 0); push_value(v2cm_pkg::ONE + 5, 0);

		// random phases over scales and points, with the three idling regimes
		for (phase = 0; phase < 38; phase++) begin
			if (phase == 13) begin
				send_idle_pct = 69;
				recv_idle_pct = 9;
			end else if (phase == 26) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			set_scale(3'($urandom_range(7)), rand_point(), rand_point());
			repeat (50) pixel_q.push_back(rand_pixel());
			if (phase == 5) begin
				// sender holds until all colors are back
				while (pixel_q.size() != 0 || s_tvalid) @(posedge clk);
				hold_send = 1;
				while (color_q.size() != 0) @(posedge clk);
				hold_send = 0;
			end
		end
		drain();
		if (errors == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end
endmodule
